// ----- design/bgmt_pkg.sv -----
package bgmt_pkg;

   localparam int GROUPS_DEFAULT     = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int OP_BITS            = 3;
   localparam int GROUP_INDEX_BITS   = 4;
   localparam int BOOST_BITS         = 7;

   localparam logic [BOOST_BITS-1:0] BOOST_LIMIT = 7'd100;

   typedef enum logic [OP_BITS-1:0] {
      OP_ENQUEUE   = 3'd0,
      OP_DEQUEUE   = 3'd1,
      OP_IDLE      = 3'd2,
      OP_SET_BOOST = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_issue;
      logic scan_end;
   } cmd_type;

   typedef struct packed {
      logic rescan;
      logic scan_last;
   } status_type;

endpackage

// ----- design/bgmt_controller.sv -----
module bgmt_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bgmt_pkg::status_type status,
   output bgmt_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import bgmt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.rescan ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            cmd.exec     = 1'b1;
            rsp_valid_in = !status.rescan;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ST_SCAN_END: begin
            cmd.scan_end = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/bgmt_datapath.sv -----
module bgmt_datapath #(
   parameter int GROUPS     = bgmt_pkg::GROUPS_DEFAULT,
   parameter int COUNT_BITS = bgmt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bgmt_pkg::cmd_type                      cmd,
   output bgmt_pkg::status_type                   status,
   input  logic [bgmt_pkg::OP_BITS-1:0]           req_operation,
   input  logic [bgmt_pkg::GROUP_INDEX_BITS-1:0]  req_group_index,
   input  logic [bgmt_pkg::BOOST_BITS-1:0]        req_boost_value,
   input  logic                                   req_task_exiting,
   output logic [bgmt_pkg::BOOST_BITS-1:0]        rsp_max_boost,
   output logic                                   rsp_rejected
);
   import bgmt_pkg::*;

   localparam int AW = $clog2(GROUPS);
   localparam int CW = ((AW > GROUP_INDEX_BITS) ? AW : GROUP_INDEX_BITS) + 1;

   // item registers
   op_type                op_ff;
   logic [AW-1:0]         addr_ff;
   logic                  in_range_ff;
   logic [BOOST_BITS-1:0] value_ff;
   logic                  exiting_ff;

   // stores: memories plus per-entry flags
   logic [BOOST_BITS-1:0] boost_mem [GROUPS];
   logic [COUNT_BITS-1:0] count_mem [GROUPS];
   logic                  boost_valid_ff [GROUPS];
   logic                  count_nz_ff [GROUPS];
   logic                  idle_mark_ff;
   logic [BOOST_BITS-1:0] current_max_ff;
   logic                  rejected_ff;

   // read port
   logic [AW-1:0]         rd_addr;
   logic [BOOST_BITS-1:0] boost_rd_ff;
   logic                  boost_rv_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic                  nz_rd_ff;
   logic [BOOST_BITS-1:0] boost_old;
   logic [COUNT_BITS-1:0] count_old;

   // scan
   logic [AW-1:0]         scan_ptr_ff;
   logic                  scan_pend_ff;
   logic                  scan_zero_ff;
   logic [BOOST_BITS-1:0] best_ff;
   logic [BOOST_BITS-1:0] best_in;

   // event decode
   logic                  cnt_we;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  bst_we;
   logic [BOOST_BITS-1:0] bst_wdata;
   logic                  idle_clr;
   logic                  idle_set;
   logic                  max_we;
   logic [BOOST_BITS-1:0] max_wdata;
   logic                  rescan;
   logic                  rejected_in;
   logic                  in_range_in;

   assign in_range_in = (CW'(req_group_index) < CW'(GROUPS));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= op_type'(req_operation);
         addr_ff     <= AW'(req_group_index);
         in_range_ff <= in_range_in;
         value_ff    <= req_boost_value;
         exiting_ff  <= req_task_exiting;
      end
   end

   assign rd_addr = cmd.capture ? AW'(req_group_index) : scan_ptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec && bst_we) boost_mem[addr_ff] <= bst_wdata;
      if (cmd.exec && cnt_we) count_mem[addr_ff] <= cnt_wdata;
      boost_rd_ff <= boost_mem[rd_addr];
      count_rd_ff <= count_mem[rd_addr];
      boost_rv_ff <= boost_valid_ff[rd_addr];
      nz_rd_ff    <= count_nz_ff[rd_addr];
   end

   // an entry without its flag reads as zero
   assign boost_old = boost_rv_ff ? boost_rd_ff : '0;
   assign count_old = nz_rd_ff ? count_rd_ff : '0;

   always_comb begin
      cnt_we      = 1'b0;
      cnt_wdata   = count_old;
      bst_we      = 1'b0;
      bst_wdata   = '0;
      idle_clr    = 1'b0;
      idle_set    = 1'b0;
      max_we      = 1'b0;
      max_wdata   = current_max_ff;
      rescan      = 1'b0;
      rejected_in = 1'b0;
      unique case (op_ff)
         OP_ENQUEUE, OP_DEQUEUE: begin
            if (!exiting_ff && in_range_ff) begin
               cnt_we   = 1'b1;
               idle_clr = 1'b1;
               if (op_ff == OP_ENQUEUE) begin
                  cnt_wdata = (count_old != '1) ? count_old + COUNT_BITS'(1) : count_old;
               end else begin
                  cnt_wdata = (count_old <= COUNT_BITS'(1)) ? '0
                                                            : count_old - COUNT_BITS'(1);
               end
               rescan = (cnt_wdata <= COUNT_BITS'(1));
            end
         end
         OP_IDLE: begin
            idle_set = !idle_mark_ff;
         end
         OP_SET_BOOST, OP_CLEAR: begin
            bst_wdata = (op_ff == OP_SET_BOOST) ? value_ff : '0;
            if (op_ff == OP_SET_BOOST && value_ff > BOOST_LIMIT) begin
               rejected_in = 1'b1;
            end else if (in_range_ff) begin
               bst_we = 1'b1;
               if (bst_wdata > current_max_ff && nz_rd_ff) begin
                  max_we    = 1'b1;
                  max_wdata = bst_wdata;
               end else if (current_max_ff == boost_old && boost_old > bst_wdata) begin
                  rescan = 1'b1;
               end
            end
         end
         default: begin
            rescan = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GROUPS; i++) begin
            boost_valid_ff[i] <= 1'b0;
            count_nz_ff[i]    <= 1'b0;
         end
         idle_mark_ff   <= 1'b0;
         current_max_ff <= '0;
         rejected_ff    <= 1'b0;
         scan_pend_ff   <= 1'b0;
         scan_ptr_ff    <= '0;
      end else begin
         scan_pend_ff <= cmd.scan_issue;
         if (cmd.exec) begin
            rejected_ff <= rejected_in;
            scan_ptr_ff <= '0;
            if (bst_we) boost_valid_ff[addr_ff] <= 1'b1;
            if (cnt_we) count_nz_ff[addr_ff] <= (cnt_wdata != '0);
            if (idle_clr) idle_mark_ff <= 1'b0;
            if (idle_set) begin
               idle_mark_ff <= 1'b1;
               // drop the tasks of every group but the root
               for (int i = 1; i < GROUPS; i++) count_nz_ff[i] <= 1'b0;
            end
            if (max_we) current_max_ff <= max_wdata;
         end
         if (cmd.scan_issue) scan_ptr_ff <= scan_ptr_ff + AW'(1);
         if (cmd.scan_end) current_max_ff <= best_in;
      end
   end

   // group 0 seeds the maximum; others count only with tasks
   always_comb begin
      best_in = best_ff;
      if (scan_pend_ff || cmd.scan_end) begin
         if (scan_zero_ff) begin
            best_in = boost_old;
         end else if (nz_rd_ff && boost_old > best_ff) begin
            best_in = boost_old;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_zero_ff <= (scan_ptr_ff == '0);
      best_ff      <= best_in;
   end

   assign status.rescan    = rescan;
   assign status.scan_last = (scan_ptr_ff == AW'(GROUPS - 1));

   assign rsp_max_boost = current_max_ff;
   assign rsp_rejected  = rejected_ff;

endmodule

// ----- design/boost_group_max_tracker.sv -----
// An event that needs no rescan passes from accept through the exec state to the
// registered rsp_valid strobe; one that does walks the scan and scan-end states first.
// One item at a time: busy is high until the strobe, and the next item may be
// accepted in the strobe cycle. A rescan walks the boost memory read port one
// group per cycle. The receiver cannot stall. Reset: synchronous, active high;
// clears all stores via flags.
module boost_group_max_tracker #(
   parameter int GROUPS     = bgmt_pkg::GROUPS_DEFAULT,
   parameter int COUNT_BITS = bgmt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [bgmt_pkg::OP_BITS-1:0]          req_operation,
   input  logic [bgmt_pkg::GROUP_INDEX_BITS-1:0] req_group_index,
   input  logic [bgmt_pkg::BOOST_BITS-1:0]       req_boost_value,
   input  logic                                  req_task_exiting,
   output logic                                  rsp_valid,
   output logic [bgmt_pkg::BOOST_BITS-1:0]       rsp_max_boost,
   output logic                                  rsp_rejected
);
   import bgmt_pkg::*;

   cmd_type    cmd;
   status_type status;

   bgmt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bgmt_datapath #(
      .GROUPS     (GROUPS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_group_index  (req_group_index),
      .req_boost_value  (req_boost_value),
      .req_task_exiting (req_task_exiting),
      .rsp_max_boost    (rsp_max_boost),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

// ----- design/bgmt_checker.sv -----
module bgmt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [bgmt_pkg::BOOST_BITS-1:0]       rsp_max_boost
);
   import bgmt_pkg::*;

   a_max_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_boost <= BOOST_LIMIT))
      else $error("max boost above limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not occupy the block");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && !$past(reset)) |-> $past(start))
      else $error("busy without an accepted item");

endmodule

bind boost_group_max_tracker bgmt_checker u_bgmt_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bgmt_pkg::*;

   localparam int GROUPS         = GROUPS_DEFAULT;
   localparam int COUNT_BITS     = COUNT_BITS_DEFAULT;
   localparam int IDLE_PCT       = 8;
   localparam int RANDOM_ITEMS   = 500;
   localparam int BURST_ITEMS    = 20;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = GROUPS + 4;
   localparam int MAX_REPORTS    = 10;
   localparam int DIRECTED_ROWS  = 24;

   localparam logic [OP_BITS-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [BOOST_BITS-1:0] max_boost;
      logic                  rejected;
   } boost_result_type;

   typedef struct packed {
      logic [OP_BITS-1:0]          op;
      logic [GROUP_INDEX_BITS-1:0] grp;
      logic [BOOST_BITS-1:0]       val;
      logic                        exiting;
      bit                          typed;
      boost_result_type            known;
   } event_row_type;

   localparam boost_result_type UNTYPED = '0;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic [OP_BITS-1:0]          req_operation = '0;
   logic [GROUP_INDEX_BITS-1:0] req_group_index = '0;
   logic [BOOST_BITS-1:0]       req_boost_value = '0;
   logic                        req_task_exiting = 1'b0;
   logic                        busy;
   logic                        rsp_valid;
   logic [BOOST_BITS-1:0]       rsp_max_boost;
   logic                        rsp_rejected;

   boost_group_max_tracker #(
      .GROUPS     (GROUPS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_group_index  (req_group_index),
      .req_boost_value  (req_boost_value),
      .req_task_exiting (req_task_exiting),
      .rsp_valid        (rsp_valid),
      .rsp_max_boost    (rsp_max_boost),
      .rsp_rejected     (rsp_rejected)
   );

   // shadow state of the tracker
   logic [BOOST_BITS-1:0] boost_tab [GROUPS];
   logic [COUNT_BITS-1:0] task_count_tab [GROUPS];
   logic                  idle_seen;
   logic [BOOST_BITS-1:0] tracked_max;

   event_row_type    issued_q[$];
   boost_result_type max_boost_q[$];
   int               failures = 0;
   int               stall_cycles = 0;
   bit               gaps_on = 1'b1;

   event_row_type directed_tab [DIRECTED_ROWS] = '{
      // op            group  boost   exit  typed expected
      '{OP_ENQUEUE,    4'd0,  7'd0,   1'b0, 1'b1, '{7'd0, 1'b0}},
      '{OP_SET_BOOST,  4'd3,  7'd100, 1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd3,  7'd127, 1'b0, 1'b1, '{7'd0, 1'b1}},
      '{OP_SET_BOOST,  4'd3,  7'd101, 1'b1, 1'b1, '{7'd0, 1'b1}},
      '{OP_ENQUEUE,    4'd3,  7'd127, 1'b0, 1'b0, UNTYPED},
      '{OP_ENQUEUE,    4'd3,  7'd0,   1'b1, 1'b0, UNTYPED},
      '{OP_DEQUEUE,    4'd3,  7'd0,   1'b1, 1'b0, UNTYPED},
      '{OP_ENQUEUE,    4'd3,  7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd15, 7'd50,  1'b0, 1'b0, UNTYPED},
      '{OP_ENQUEUE,    4'd15, 7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd3,  7'd20,  1'b0, 1'b0, UNTYPED},
      '{OP_DEQUEUE,    4'd15, 7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_DEQUEUE,    4'd15, 7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd0,  7'd100, 1'b0, 1'b0, UNTYPED},
      '{OP_CLEAR,      4'd0,  7'd127, 1'b0, 1'b0, UNTYPED},
      '{OP_IDLE,       4'd0,  7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_IDLE,       4'd15, 7'd127, 1'b1, 1'b0, UNTYPED},
      '{OP_SPARE_5,    4'd7,  7'd127, 1'b1, 1'b0, UNTYPED},
      '{OP_SPARE_6,    4'd9,  7'd64,  1'b0, 1'b0, UNTYPED},
      '{OP_SPARE_7,    4'd15, 7'd1,   1'b1, 1'b0, UNTYPED},
      '{OP_ENQUEUE,    4'd1,  7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd2,  7'd100, 1'b0, 1'b0, UNTYPED},
      '{OP_CLEAR,      4'd3,  7'd0,   1'b0, 1'b0, UNTYPED},
      '{OP_SET_BOOST,  4'd1,  7'd100, 1'b0, 1'b0, UNTYPED}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [BOOST_BITS-1:0] scan_max();
      logic [BOOST_BITS-1:0] best;
      best = boost_tab[0];
      for (int g = 1; g < GROUPS; g++) begin
         if (task_count_tab[g] != '0 && boost_tab[g] > best) best = boost_tab[g];
      end
      return best;
   endfunction

   function automatic void write_group_boost(input int g, input logic [BOOST_BITS-1:0] v);
      logic [BOOST_BITS-1:0] old;
      old = boost_tab[g];
      boost_tab[g] = v;
      if (v > tracked_max && task_count_tab[g] != '0) begin
         tracked_max = v;
      end else if (tracked_max == old && old > v) begin
         tracked_max = scan_max();
      end
   endfunction

   function automatic boost_result_type apply_event(input logic [OP_BITS-1:0] op,
                                                    input logic [GROUP_INDEX_BITS-1:0] grp,
                                                    input logic [BOOST_BITS-1:0] val,
                                                    input logic exiting);
      boost_result_type res;
      logic [COUNT_BITS-1:0] cnt;
      res = '0;
      case (op)
         OP_ENQUEUE, OP_DEQUEUE: begin
            if (!exiting && int'(grp) < GROUPS) begin
               idle_seen = 1'b0;
               cnt = task_count_tab[grp];
               if (op == OP_ENQUEUE) begin
                  if (cnt != '1) cnt = cnt + 1'b1;
               end else begin
                  // floor at zero
                  if (cnt != '0) cnt = cnt - 1'b1;
               end
               task_count_tab[grp] = cnt;
               if (cnt <= 1) tracked_max = scan_max();
            end
         end
         OP_IDLE: begin
            if (!idle_seen) begin
               idle_seen = 1'b1;
               for (int g = 1; g < GROUPS; g++) task_count_tab[g] = '0;
            end
         end
         OP_SET_BOOST: begin
            if (val > BOOST_LIMIT) res.rejected = 1'b1;
            else if (int'(grp) < GROUPS) write_group_boost(grp, val);
         end
         OP_CLEAR: begin
            if (int'(grp) < GROUPS) write_group_boost(grp, '0);
         end
         default: ;
      endcase
      res.max_boost = tracked_max;
      return res;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   // score results and predict on each accepted item
   always @(posedge clock) begin
      boost_result_type want;
      event_row_type    row;
      if (reset) begin
         for (int g = 0; g < GROUPS; g++) begin
            boost_tab[g] = '0;
            task_count_tab[g] = '0;
         end
         idle_seen = 1'b0;
         tracked_max = '0;
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (max_boost_q.size() == 0) begin
               note_failure($sformatf("result with none pending: max_boost %0d rejected %0b",
                                      rsp_max_boost, rsp_rejected));
            end else begin
               want = max_boost_q.pop_front();
               if (rsp_max_boost !== want.max_boost || rsp_rejected !== want.rejected)
                  note_failure($sformatf("expected max_boost %0d rejected %0b, got %0d %0b",
                                         want.max_boost, want.rejected,
                                         rsp_max_boost, rsp_rejected));
            end
         end
         if (start && !busy) begin
            row = issued_q.pop_front();
            want = apply_event(req_operation, req_group_index, req_boost_value,
                               req_task_exiting);
            if (row.typed) want = row.known;
            max_boost_q.push_back(want);
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("boost_group_max_tracker verification failed");
            $finish;
         end
      end
   end

   // present one item and hold it until accepted
   task automatic issue(input event_row_type row);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= row.op;
      req_group_index  <= row.grp;
      req_boost_value  <= row.val;
      req_task_exiting <= row.exiting;
      issued_q.push_back(row);
      do @(posedge clock); while (busy);
   endtask

   initial begin
      event_row_type row;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_tab[i]) issue(directed_tab[i]);

      // drive one group's count up, then back off
      row = '0;
      row.op = OP_ENQUEUE;
      row.grp = 4'd5;
      for (int n = 0; n < BURST_ITEMS; n++) issue(row);
      row.op = OP_DEQUEUE;
      issue(row);
      row.op = OP_SET_BOOST;
      row.val = 7'd90;
      issue(row);
      row.op = OP_IDLE;
      issue(row);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on = (n < 200 || n >= 330);
         row = '0;
         pick = $urandom_range(99);
         if (pick < 35) row.op = OP_ENQUEUE;
         else if (pick < 60) row.op = OP_DEQUEUE;
         else if (pick < 80) row.op = OP_SET_BOOST;
         else if (pick < 87) row.op = OP_CLEAR;
         else if (pick < 92) row.op = OP_IDLE;
         else if (pick < 95) row.op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
         else row.op = OP_ENQUEUE;
         // favor a few groups so counts build up
         row.grp = ($urandom_range(9) < 7) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
         if (row.op == OP_SET_BOOST && $urandom_range(9) != 0)
            row.val = 7'($urandom_range(BOOST_LIMIT));
         else if (row.op == OP_SET_BOOST)
            row.val = 7'($urandom_range(127, BOOST_LIMIT + 1));
         else
            row.val = 7'($urandom_range(127));
         row.exiting = ($urandom_range(9) == 0);
         issue(row);
      end
      start <= 1'b0;

      while (issued_q.size() != 0 || max_boost_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("boost_group_max_tracker verification clean");
      end else begin
         $display("boost_group_max_tracker verification failed");
      end
      $finish;
   end

endmodule
